FILE: rtl/ipcmbx_pkg.sv
// ----------------------------------------------------------------------------
// IPC mailbox package
// Shared types, result codes, control bits and register indexes of the
// mailbox reply flow control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ipcmbx_pkg;

	// Ring depth default and counter geometry
	localparam int DEFAULT_RING_DEPTH = 48;
	localparam int CNT_W              = 6;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM2_BASE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM1_END      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_BYTES = 2'd3;

	// Configuration reset values
	localparam logic [31:0] RST_MEM2_BASE     = 32'h1000_0000;
	localparam logic [31:0] RST_HEAP_LIMIT    = 32'h1310_0000;
	localparam logic [31:0] RST_MEM1_END      = 32'h0180_0000;
	localparam logic [7:0]  RST_REQUEST_BYTES = 8'd64;

	// Control register bits
	localparam logic [3:0] CTL_OUT      = 4'h1;
	localparam logic [3:0] CTL_RELAUNCH = 4'h2;
	localparam logic [3:0] CTL_IN       = 4'h4;
	localparam logic [3:0] CTL_ACK      = 4'h8;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_MSG_WR        = 3'd0,
		KIND_CTL_WR        = 3'd1,
		KIND_REQ_ACCEPT    = 3'd2,
		KIND_REQ_REJECT    = 3'd3,
		KIND_UNKNOWN_IRQ   = 3'd4,
		KIND_RING_OVERFLOW = 3'd5
	} kind_t;

	// Source of a result value
	typedef enum logic [2:0] {
		VSEL_ZERO,
		VSEL_REPLY,
		VSEL_REQ,
		VSEL_RING,
		VSEL_CTL
	} vsel_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EMIT_OVF,
		ST_EMIT_RELAUNCH,
		ST_EMIT_UNKNOWN,
		ST_EMIT_IN_CTL,
		ST_IN_RESULT,
		ST_SEND_RD,
		ST_SEND_MSG,
		ST_SEND_CTL
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       capture;
		logic       push;
		logic       set_credit;
		logic       inc_outstanding;
		logic       send_advance;
		logic       load_out;
		kind_t      out_kind;
		vsel_t      out_sel;
		logic [3:0] out_ctl;
		logic       out_last;
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic req_type;
		logic relaunch;
		logic incoming;
		logic ring_full;
		logic ready_nonzero;
		logic credit;
		logic below_ack;
		logic at_ack;
		logic addr_ok;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/ipcmbx_ctrl.sv
// ----------------------------------------------------------------------------
// IPC mailbox controller
// Walks one request through dispatch, result emission and the ring send.
// ----------------------------------------------------------------------------
`default_nettype none

module ipcmbx_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire ipcmbx_pkg::dp_status_t st,
	output ipcmbx_pkg::ctl_cmd_t        cmd
);
	import ipcmbx_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold off new requests until the current one has emitted all its results
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (!st.req_type) begin
					if (st.ring_full) begin
						state_d = ST_EMIT_OVF;
					end else begin
						cmd.push = 1'b1;
						// the push makes the ring non-empty
						state_d  = st.credit ? ST_SEND_RD : ST_IDLE;
					end
				end else if (st.relaunch) begin
					cmd.set_credit = 1'b1;
					state_d        = ST_EMIT_RELAUNCH;
				end else if (!st.incoming) begin
					state_d = ST_EMIT_UNKNOWN;
				end else begin
					state_d = ST_EMIT_IN_CTL;
				end
			end
			ST_EMIT_OVF: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = KIND_RING_OVERFLOW;
					cmd.out_sel  = VSEL_REPLY;
					cmd.out_last = !(st.credit && st.ready_nonzero);
					state_d      = (st.credit && st.ready_nonzero) ? ST_SEND_RD : ST_IDLE;
				end
			end
			ST_EMIT_RELAUNCH: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = KIND_CTL_WR;
					cmd.out_sel  = VSEL_CTL;
					cmd.out_ctl  = CTL_RELAUNCH;
					cmd.out_last = !st.ready_nonzero;
					state_d      = st.ready_nonzero ? ST_SEND_RD : ST_IDLE;
				end
			end
			ST_EMIT_UNKNOWN: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = KIND_UNKNOWN_IRQ;
					cmd.out_sel  = VSEL_ZERO;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_EMIT_IN_CTL: begin
				if (st.out_free) begin
					cmd.load_out        = 1'b1;
					cmd.out_kind        = KIND_CTL_WR;
					cmd.out_sel         = VSEL_CTL;
					cmd.out_ctl         = CTL_IN | (st.below_ack ? CTL_ACK : 4'h0);
					cmd.inc_outstanding = 1'b1;
					state_d             = ST_IN_RESULT;
				end
			end
			ST_IN_RESULT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = st.addr_ok ? KIND_REQ_ACCEPT : KIND_REQ_REJECT;
					cmd.out_sel  = VSEL_REQ;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_SEND_RD: begin
				// ring head read is in flight
				state_d = ST_SEND_MSG;
			end
			ST_SEND_MSG: begin
				if (st.out_free) begin
					cmd.load_out     = 1'b1;
					cmd.out_kind     = KIND_MSG_WR;
					cmd.out_sel      = VSEL_RING;
					cmd.send_advance = 1'b1;
					state_d          = ST_SEND_CTL;
				end
			end
			ST_SEND_CTL: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = KIND_CTL_WR;
					cmd.out_sel  = VSEL_CTL;
					cmd.out_ctl  = CTL_OUT | (st.at_ack ? CTL_ACK : 4'h0);
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/ipcmbx_dpath.sv
// ----------------------------------------------------------------------------
// IPC mailbox datapath
// Request capture, configuration registers, reply ring, counters, request
// range check and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipcmbx_dpath #(
	parameter int RING_DEPTH = ipcmbx_pkg::DEFAULT_RING_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request payload
	input  wire logic                              req_type,
	input  wire logic [31:0]                       reply_addr,
	input  wire logic                              flag_relaunch,
	input  wire logic                              flag_incoming,
	input  wire logic [31:0]                       request_addr,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [ipcmbx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                       cfg_data,
	// control
	input  wire ipcmbx_pkg::ctl_cmd_t              cmd,
	output ipcmbx_pkg::dp_status_t                 st,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [2:0]                             kind,
	output logic [31:0]                            value,
	output logic                                   last
);
	import ipcmbx_pkg::*;

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(RING_DEPTH);
	localparam logic [CNT_W-1:0]  ACK_LIMIT = CNT_W'(RING_DEPTH - 1);

	// Configuration registers
	logic [31:0] mem2_base_q;
	logic [31:0] heap_limit_q;
	logic [31:0] mem1_end_q;
	logic [7:0]  request_bytes_q;

	// Captured request
	logic        req_type_q;
	logic [31:0] reply_addr_q;
	logic        relaunch_q;
	logic        incoming_q;
	logic [31:0] request_addr_q;

	// Ring and its bookkeeping
	logic [31:0]       ring_q [RING_DEPTH];
	logic [31:0]       rd_data_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic [CNT_W-1:0]  ready_count_q;
	logic [CNT_W-1:0]  outstanding_q;
	logic              credit_q;

	// Range check
	logic [32:0] end_sum;
	logic [31:0] end_q;
	logic        nowrap_q;
	logic        base_ok_q;
	logic        addr_ok_q;

	// Result register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [31:0] value_q;
	logic        last_q;
	logic [31:0] value_d;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem2_base_q     <= RST_MEM2_BASE;
			heap_limit_q    <= RST_HEAP_LIMIT;
			mem1_end_q      <= RST_MEM1_END;
			request_bytes_q <= RST_REQUEST_BYTES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MEM2_BASE:     mem2_base_q     <= cfg_data;
				CFG_HEAP_LIMIT:    heap_limit_q    <= cfg_data;
				CFG_MEM1_END:      mem1_end_q      <= cfg_data;
				CFG_REQUEST_BYTES: request_bytes_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Capture the accepted request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q     <= req_type;
			reply_addr_q   <= reply_addr;
			relaunch_q     <= flag_relaunch;
			incoming_q     <= flag_incoming;
			request_addr_q <= request_addr;
		end
	end

	// Ring memory: write on push, registered read of the head every cycle
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_q[write_slot_q] <= reply_addr_q;
		end
		rd_data_q <= ring_q[read_slot_q];
	end

	// Slots, counts and send credit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q  <= '0;
			read_slot_q   <= '0;
			ready_count_q <= '0;
			outstanding_q <= '0;
			credit_q      <= 1'b0;
		end else begin
			if (cmd.push) begin
				write_slot_q  <= (write_slot_q == SLOT_LAST) ? '0 : write_slot_q + 1'b1;
				ready_count_q <= ready_count_q + 1'b1;
			end
			if (cmd.set_credit) begin
				credit_q <= 1'b1;
			end
			if (cmd.inc_outstanding && outstanding_q != CNT_MAX) begin
				outstanding_q <= outstanding_q + 1'b1;
			end
			// advance the head after a send
			if (cmd.send_advance) begin
				read_slot_q   <= (read_slot_q == SLOT_LAST) ? '0 : read_slot_q + 1'b1;
				ready_count_q <= ready_count_q - 1'b1;
				credit_q      <= 1'b0;
				if (outstanding_q != '0) begin
					outstanding_q <= outstanding_q - 1'b1;
				end
			end
		end
	end

	// Range check: end bound and base compare, then the window compares
	assign end_sum = {1'b0, request_addr_q} + {25'd0, request_bytes_q};

	always_ff @(posedge clk) begin
		end_q     <= end_sum[31:0];
		nowrap_q  <= !end_sum[32] && (request_bytes_q != 8'd0);
		base_ok_q <= (mem2_base_q <= request_addr_q);
		addr_ok_q <= nowrap_q
			&& ((base_ok_q && (end_q <= heap_limit_q)) || (end_q <= mem1_end_q));
	end

	// Result value selection
	always_comb begin
		unique case (cmd.out_sel)
			VSEL_ZERO:  value_d = '0;
			VSEL_REPLY: value_d = reply_addr_q;
			VSEL_REQ:   value_d = request_addr_q;
			VSEL_RING:  value_d = rd_data_q;
			VSEL_CTL:   value_d = {28'd0, cmd.out_ctl};
			default:    value_d = '0;
		endcase
	end

	// Result register: load when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind_q  <= cmd.out_kind;
			value_q <= value_d;
			last_q  <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

	// Status to the controller
	assign st.req_type      = req_type_q;
	assign st.relaunch      = relaunch_q;
	assign st.incoming      = incoming_q;
	assign st.ring_full     = (ready_count_q == DEPTH_CNT);
	assign st.ready_nonzero = (ready_count_q != '0);
	assign st.credit        = credit_q;
	assign st.below_ack     = (outstanding_q < ACK_LIMIT);
	assign st.at_ack        = (outstanding_q == ACK_LIMIT);
	assign st.addr_ok       = addr_ok_q;
	assign st.out_free      = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

FILE: rtl/ipc_mailbox_reply_flow_control_unit.sv
// Flow: an accepted request is captured and dispatched, then its results
// are registered one by one; a ring send first reads the ring head.
// A new request is held off until the current one is done, and a stalled
// result output holds the flow.
// Reset: asynchronous, clears state, counters, credit and config to defaults;
// the ring contents are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// IPC mailbox reply flow control unit
// Queues reply addresses, sends them under relaunch credit, acknowledges
// incoming requests with deferral and range-checks the request address.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_mailbox_reply_flow_control_unit #(
	parameter int RING_DEPTH = ipcmbx_pkg::DEFAULT_RING_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             req_type,
	input  wire logic [31:0]                      reply_addr,
	input  wire logic                             flag_relaunch,
	input  wire logic                             flag_incoming,
	input  wire logic [31:0]                      request_addr,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [ipcmbx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                      cfg_data,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [2:0]                            kind,
	output logic [31:0]                           value,
	output logic                                  last
);
	import ipcmbx_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t st;

	ipcmbx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ipcmbx_dpath #(
		.RING_DEPTH (RING_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.reply_addr    (reply_addr),
		.flag_relaunch (flag_relaunch),
		.flag_incoming (flag_incoming),
		.request_addr  (request_addr),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.st            (st),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.value         (value),
		.last          (last)
	);

endmodule

`default_nettype wire

FILE: rtl/ipcmbx_checker.sv
// ----------------------------------------------------------------------------
// IPC mailbox port checker
// Port-level properties of the mailbox unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipcmbx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  kind,
	input wire logic [31:0] value,
	input wire logic        last
);
	import ipcmbx_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value)
			&& $stable(last))
		else $error("stalled result changed");

	// One request at a time: an accepted request blocks the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while previous one in dispatch");

	// Only defined result kinds
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 3'd6 && kind != 3'd7)
		else $error("undefined result kind");

	// An unknown interrupt is a lone result with zero value
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_UNKNOWN_IRQ |-> last && value == 32'd0)
		else $error("unknown interrupt result malformed");

	// A message register write is always followed by its control write
	a_msg_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_MSG_WR |-> !last)
		else $error("message write flagged as last");

endmodule

bind ipc_mailbox_reply_flow_control_unit ipcmbx_checker u_ipcmbx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.value     (value),
	.last      (last)
);

`default_nettype wire
